### src/stis_pkg.sv
package stis_pkg;

  // Result codes carried on the status field.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // Item modes.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // Output field widths.
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_START,
    S_INS_SHIFT,
    S_SRCH_PROBE,
    S_SRCH_CMP,
    S_RESP
  } state_t;

  // One result beat.
  typedef struct packed {
    status_t             status;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  entry_count;
  } result_t;

endpackage

### src/sorted_table_insert_search_core.sv
// Sorted table with ordered insert and binary search.
// Input channel (in_valid/in_stall) carries mode and value; mode 0 inserts the
// value after any equal entries, mode 1 searches for it. Each accepted beat
// gives exactly one result beat on the output channel (out_valid/out_stall)
// with status, position and entry_count.
// One item is worked on at a time; in_stall is high from acceptance until its
// result is loaded into the output register.
// Insert: the entries above the new value are moved up one slot at a time,
// with one memory read and one write per cycle on the table memory.
// Search: each probe is a read, then a compare; the search ends on a hit,
// or with a miss once the range is empty.
// An insert into a full table is refused with status ST_FULL.
// Reset clears only the state, the fill count and out_valid; the table memory
// needs no clearing pass because data read from unfilled slots is never used.
// When the receiver stalls, the finished result waits in the output register
// while the next item is accepted; a further result waits inside the core
// until the output register frees.
module sorted_table_insert_search_core
  import stis_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                mode,
  input  logic signed [31:0]  value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [POS_W-1:0]    position,
  output logic [COUNT_W-1:0]  entry_count
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t              state, state_next;
  logic signed [31:0]  key, key_next;
  logic [AW-1:0]       slot, slot_next;
  logic [AW-1:0]       mid, mid_next;
  logic [CW-1:0]       low, low_next;
  logic [CW-1:0]       hi, hi_next;
  logic [CW-1:0]       count, count_next;
  result_t             res, res_next;

  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [31:0]         mem_wdata;
  logic signed [31:0]  rd_data;
  logic                out_load, out_free;
  logic [CW:0]         mid_sum;
  logic [AW-1:0]       mid_calc;

  assign in_stall = (state != S_IDLE);

  // Midpoint of [low, hi-1], rounded down; only used while low < hi.
  assign mid_sum  = {1'b0, low} + {1'b0, hi} - {{CW{1'b0}}, 1'b1};
  assign mid_calc = AW'(mid_sum >> 1);

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    key    <= key_next;
    slot   <= slot_next;
    mid    <= mid_next;
    low    <= low_next;
    hi     <= hi_next;
    res    <= res_next;
  end

  // Sequencer: next state, memory accesses and result.
  always_comb begin
    state_next  = state;
    key_next    = key;
    slot_next   = slot;
    mid_next    = mid;
    low_next    = low;
    hi_next     = hi;
    count_next  = count;
    res_next    = res;
    mem_we      = 1'b0;
    mem_waddr   = slot;
    mem_wdata   = key;
    mem_re      = 1'b0;
    mem_raddr   = mid_calc;
    out_load    = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          key_next    = value;
          low_next    = '0;
          hi_next     = count;
          state_next  = (mode == MODE_INSERT) ? S_INS_START : S_SRCH_PROBE;
        end
      end

      S_INS_START: begin
        if (count >= CW'(TABLE_DEPTH)) begin
          res_next.status      = ST_FULL;
          res_next.position    = '0;
          res_next.entry_count = COUNT_W'(count);
          state_next           = S_RESP;
        end else begin
          // Fetch the top filled entry for the first compare.
          slot_next  = AW'(count);
          mem_re     = 1'b1;
          mem_raddr  = AW'(count - CW'(1));
          state_next = S_INS_SHIFT;
        end
      end

      S_INS_SHIFT: begin
        // rd_data holds entry slot-1 when slot is nonzero.
        if (slot != '0 && key < rd_data) begin
          mem_we    = 1'b1;
          mem_waddr = slot;
          mem_wdata = rd_data;
          slot_next = slot - AW'(1);
          mem_re    = 1'b1;
          mem_raddr = slot - AW'(2);
        end else begin
          mem_we               = 1'b1;
          mem_waddr            = slot;
          mem_wdata            = key;
          count_next           = count + CW'(1);
          res_next.status      = ST_OK;
          res_next.position    = POS_W'(slot);
          res_next.entry_count = COUNT_W'(count + CW'(1));
          state_next           = S_RESP;
        end
      end

      S_SRCH_PROBE: begin
        if (low < hi) begin
          mem_re     = 1'b1;
          mem_raddr  = mid_calc;
          mid_next   = mid_calc;
          state_next = S_SRCH_CMP;
        end else begin
          res_next.status      = ST_NOT_FOUND;
          res_next.position    = '0;
          res_next.entry_count = COUNT_W'(count);
          state_next           = S_RESP;
        end
      end

      S_SRCH_CMP: begin
        priority if (rd_data == key) begin
          res_next.status      = ST_OK;
          res_next.position    = POS_W'(mid);
          res_next.entry_count = COUNT_W'(count);
          state_next           = S_RESP;
        end else if (key > rd_data) begin
          low_next   = CW'(mid) + CW'(1);
          state_next = S_SRCH_PROBE;
        end else begin
          hi_next    = CW'(mid);
          state_next = S_SRCH_PROBE;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  stis_table_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (32)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  stis_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (out_load),
    .res         (res),
    .free        (out_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .position    (position),
    .entry_count (entry_count)
  );

  // The fill count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("fill count above table depth");

  // The fill count only ever grows by one.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && count != $past(count) |-> count == $past(count) + CW'(1))
    else $error("fill count changed by other than one");

  // Table writes happen only while a free slot remains.
  a_write_room: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> count < CW'(TABLE_DEPTH))
    else $error("table write with a full table");

  // A compare always follows a probe inside a nonempty range.
  a_search_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SRCH_CMP |-> low < hi && CW'(mid) < hi)
    else $error("search probe outside its range");

endmodule

### src/stis_table_ram.sv
module stis_table_ram
  import stis_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/stis_out_stage.sv
module stis_out_stage
  import stis_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  result_t             res,
  output logic                free,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [POS_W-1:0]    position,
  output logic [COUNT_W-1:0]  entry_count
);

  result_t hold;

  // The register can take a new beat when empty or when its beat leaves now.
  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload holds while stalled.
  always_ff @(posedge clk) begin
    if (load) begin
      hold <= res;
    end
  end

  assign status      = hold.status;
  assign position    = hold.position;
  assign entry_count = hold.entry_count;

endmodule
